// ===== hdl/sorted_priority_queue_macros.svh =====
// Assertion macros for the sorted priority queue.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_priority_queue: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_priority_queue: assertion failed");

`else

`define SPQ_ASSERT_NOW(lbl, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/spq_pkg.sv =====
package spq_pkg;

	// Default number of cells in the queue.
	localparam int CAPACITY_DEF = 64;

	// Data and result field widths.
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;

	// Command codes.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_POP_EMPTY = 2'd1,
		STATUS_PUSH_FULL = 2'd2
	} status_t;

	// Operation applied to every cell in the same cycle.
	typedef struct packed {
		logic push;
		logic pop;
	} spq_ctrl_t;

	// What one cell hands to its neighbours.
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     gt;
	} spq_link_t;

endpackage

// ===== hdl/sorted_priority_queue.sv =====
// Output: a result appears on out_valid in the cycle after its transaction is accepted.
// Throughput: one push or pop per cycle; the row of cells compares and shifts in parallel,
// and the output register is the only thing that can hold the input back.
// Reset: arst_n clears the entry count and the output valid; cell contents are not reset
// and are only read below the entry count.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic signed [spq_pkg::DATA_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [spq_pkg::DATA_W-1:0]  top_value,
	output logic                                is_empty,
	output logic [spq_pkg::COUNT_W-1:0]         entry_count,
	output logic [1:0]                          status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                              in_accept;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  count_next;
	logic                              is_pop;
	logic                              is_full;
	logic                              is_none;
	spq_pkg::spq_ctrl_t                ctrl;
	spq_pkg::spq_link_t                head_link;
	spq_pkg::spq_link_t                links [CAPACITY];
	logic signed [spq_pkg::DATA_W-1:0] head_next;
	spq_pkg::status_t                  status_next;

	logic                              out_valid_q;
	logic signed [spq_pkg::DATA_W-1:0] top_value_q;
	logic                              is_empty_q;
	logic [spq_pkg::COUNT_W-1:0]       entry_count_q;
	spq_pkg::status_t                  status_q;

	// Input is held only while a finished result still waits downstream.
	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	assign is_pop  = (command == spq_pkg::CMD_POP);
	assign is_full = (count_q == CNT_W'(CAPACITY));
	assign is_none = (count_q == '0);

	// Operation broadcast to the whole row of cells.
	assign ctrl.push = in_accept && !is_pop && !is_full;
	assign ctrl.pop  = in_accept && is_pop && !is_none;

	// The head cell always sees a greater left neighbour, so it takes the new value when its own entry is not greater.
	assign head_link.value = '0;
	assign head_link.gt    = 1'b1;

	// Row of cells, head at index zero.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		spq_pkg::spq_link_t                left_link;
		logic signed [spq_pkg::DATA_W-1:0] right_val;

		if (g == 0) begin : g_head
			assign left_link = head_link;
		end else begin : g_body
			assign left_link = links[g-1];
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign right_val = '0;
		end else begin : g_inner
			assign right_val = links[g+1].value;
		end

		spq_cell #(
			.IDX   (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.new_value   (value),
			.left        (left_link),
			.right_value (right_val),
			.link        (links[g])
		);
	end

	// Count and head value as they will stand after this transaction.
	always_comb begin
		count_next = count_q;
		head_next  = links[0].value;
		if (ctrl.push) begin
			count_next = count_q + CNT_W'(1);
			head_next  = links[0].gt ? links[0].value : value;
		end else if (ctrl.pop) begin
			count_next = count_q - CNT_W'(1);
			head_next  = links[1].value;
		end
	end

	// Status of the transaction.
	always_comb begin
		status_next = spq_pkg::STATUS_OK;
		if (is_pop && is_none) begin
			status_next = spq_pkg::STATUS_POP_EMPTY;
		end else if (!is_pop && is_full) begin
			status_next = spq_pkg::STATUS_PUSH_FULL;
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_accept) begin
			count_q <= count_next;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded with each accepted transaction.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			top_value_q   <= (count_next == '0) ? '0 : head_next;
			is_empty_q    <= (count_next == '0);
			entry_count_q <= spq_pkg::COUNT_W'(count_next);
			status_q      <= status_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign top_value   = top_value_q;
	assign is_empty    = is_empty_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;

	// The count never exceeds the number of cells.
	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
	// The input is only held back by a waiting result.
	`SPQ_ASSERT_NOW(a_stall_cause, in_stall, out_valid_q)
	// A pop on an empty queue reports the error and an empty queue.
	`SPQ_ASSERT_NEXT(a_pop_empty, in_accept && is_pop && is_none, status_q == spq_pkg::STATUS_POP_EMPTY && is_empty_q && out_valid_q)
	// A successful push grows the count by one.
	`SPQ_ASSERT_NEXT(a_push_count, ctrl.push, count_q == $past(count_q) + CNT_W'(1))

endmodule

// ===== hdl/spq_cell.sv =====
module spq_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic                              clk,
	input  spq_pkg::spq_ctrl_t                ctrl,
	input  logic [CNT_W-1:0]                  count,
	input  logic signed [spq_pkg::DATA_W-1:0] new_value,
	input  spq_pkg::spq_link_t                left,
	input  logic signed [spq_pkg::DATA_W-1:0] right_value,
	output spq_pkg::spq_link_t                link
);

	logic signed [spq_pkg::DATA_W-1:0] value_q;
	logic                              occupied;
	logic                              gt;

	// The cell holds a live entry when its position is below the count.
	assign occupied = count > CNT_W'(IDX);

	// A live entry strictly greater than the new value stays where it is.
	assign gt = occupied && (value_q > new_value);

	// On a push the first cell not greater takes the new value and the rest
	// take their left neighbour's value; on a pop every cell takes its right
	// neighbour's value.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (!gt) begin
				value_q <= left.gt ? new_value : left.value;
			end
		end else if (ctrl.pop) begin
			value_q <= right_value;
		end
	end

	assign link.value = value_q;
	assign link.gt    = gt;

endmodule
